FILE: rtl/snell_refraction_vector_defines.svh
// Assertion macros shared by the refraction pipeline.
`ifndef SNELL_REFRACTION_VECTOR_DEFINES_SVH
`define SNELL_REFRACTION_VECTOR_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SRV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SRV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/srv_pkg.sv
// Shared types and constants of the refraction pipeline.
package srv_pkg;

	localparam int RAD_W  = 128;
	localparam int ROOT_W = 64;

	localparam logic [1:0] OUT_KEEP    = 2'd0;
	localparam logic [1:0] OUT_REFRACT = 2'd1;
	localparam logic [1:0] OUT_REFLECT = 2'd2;

	localparam logic [62:0] TOL_RESET = 63'd4611686018;

	typedef logic [63:0]  word_t;
	typedef logic [127:0] dword_t;

	typedef struct packed {
		logic [63:0] ll;
		logic [63:0] lh;
		logic [63:0] hl;
		logic [63:0] hh;
	} pp_t;

	typedef struct packed {
		logic [2:0][63:0] dir;
		logic [2:0][63:0] nrm;
		logic [62:0]      n1;
		logic [62:0]      n2;
		logic [63:0]      c1;
		logic             flip;
		logic             keep;
	} ctx_t;

	typedef struct packed {
		ctx_t        ctx;
		logic        tir;
		logic [63:0] p;
	} pay2_t;

	typedef struct packed {
		ctx_t             ctx;
		logic [1:0]       code;
		logic [2:0][63:0] vm;
		logic [2:0]       vn;
	} pay3_t;

endpackage

FILE: rtl/snell_refraction_vector.sv
// Snell's-law redirection of a unit direction at a material boundary, fully pipelined.
//
//  channel   signals                          payload
//  item      item_valid / item_stall          dir, normal, indices, flags, step_length
//  result    result_valid / result_stall      new_x, new_y, new_z, outcome
//  config    cfg_valid / cfg_ready            cfg_data (surface_tolerance)
//
// One beat enters every cycle while item_stall is low.
// The pipeline is built around three 64-stage square-root pipelines and two long dividers.
// Reset clears all valid bits and loads the tolerance register with its default.
// A stalled result freezes the whole pipeline, so the item side stalls in the same cycle.
`include "snell_refraction_vector_defines.svh"

module snell_refraction_vector import srv_pkg::*; #(
	parameter int FRAC_BITS = 62
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [62:0]        cfg_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [63:0] dir_x,
	input  logic signed [63:0] dir_y,
	input  logic signed [63:0] dir_z,
	input  logic signed [63:0] normal_x,
	input  logic signed [63:0] normal_y,
	input  logic signed [63:0] normal_z,
	input  logic [62:0]        index_before,
	input  logic [62:0]        index_after,
	input  logic               at_boundary,
	input  logic               same_material,
	input  logic [62:0]        step_length,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [63:0] new_x,
	output logic signed [63:0] new_y,
	output logic signed [63:0] new_z,
	output logic [1:0]         outcome
);

	localparam int     F    = FRAC_BITS;
	localparam word_t  ONE  = word_t'(1) << F;
	localparam dword_t ONE2 = dword_t'(1) << (2 * F);

	function automatic pp_t mul_pp(input word_t a, input word_t b);
		pp_t r;
		r.ll = 64'(a[31:0])  * 64'(b[31:0]);
		r.lh = 64'(a[31:0])  * 64'(b[63:32]);
		r.hl = 64'(a[63:32]) * 64'(b[31:0]);
		r.hh = 64'(a[63:32]) * 64'(b[63:32]);
		return r;
	endfunction

	function automatic dword_t pp_sum(input pp_t p);
		return {p.hh, 64'd0} + {32'd0, p.lh, 32'd0} + {32'd0, p.hl, 32'd0} + {64'd0, p.ll};
	endfunction

	function automatic word_t sat_mag(input word_t v);
		word_t m;
		m = v[63] ? word_t'(-v) : v;
		if (m > ONE) begin
			m = ONE;
		end
		return m;
	endfunction

	logic        en;
	logic [62:0] tol_q;

	assign en         = !result_valid || !result_stall;
	assign item_stall = !en;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	// Front end: dot product, incidence cosine and first radicand.
	ctx_t      ctx_in;
	pp_t [2:0] pp_in;
	logic [2:0] neg_in;

	always_comb begin
		ctx_in.dir   = {dir_z, dir_y, dir_x};
		ctx_in.nrm   = {normal_z, normal_y, normal_x};
		ctx_in.n1    = (index_before == '0) ? 63'd1 : index_before;
		ctx_in.n2    = (index_after == '0) ? 63'd1 : index_after;
		ctx_in.c1    = '0;
		ctx_in.flip  = 1'b0;
		ctx_in.keep  = !at_boundary || ({step_length, 1'b0} <= {1'b0, tol_q}) || same_material;
		for (int j = 0; j < 3; j++) begin
			pp_in[j]  = mul_pp(sat_mag(ctx_in.dir[j]), sat_mag(ctx_in.nrm[j]));
			neg_in[j] = ctx_in.dir[j][63] ^ ctx_in.nrm[j][63];
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6;
	pp_t [2:0]    pp_s1;
	logic [2:0]   neg_s1, neg_s2;
	dword_t [2:0] prod_s2;
	dword_t       dot_s3;
	pp_t          pp_s5;
	dword_t       rad_s6;

	dword_t abs4;
	dword_t sh4;
	ctx_t   ctx4_d;
	ctx_t   ctx5_d;

	always_comb begin
		abs4        = dot_s3[127] ? dword_t'(-dot_s3) : dot_s3;
		sh4         = abs4 >> F;
		ctx4_d      = ctx_s3;
		ctx4_d.c1   = (sh4[63:0] > ONE) ? ONE : sh4[63:0];
		ctx4_d.flip = !dot_s3[127] && (dot_s3 != '0);
	end

	always_comb begin
		ctx5_d      = ctx_s4;
		ctx5_d.keep = ctx_s4.keep || ((ctx_s4.c1 + {1'b0, tol_q}) >= ONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_in;
			pp_s1  <= pp_in;
			neg_s1 <= neg_in;
			ctx_s2 <= ctx_s1;
			neg_s2 <= neg_s1;
			for (int j = 0; j < 3; j++) begin
				prod_s2[j] <= pp_sum(pp_s1[j]);
			end
			ctx_s3 <= ctx_s2;
			dot_s3 <= (neg_s2[0] ? dword_t'(-prod_s2[0]) : prod_s2[0])
				+ (neg_s2[1] ? dword_t'(-prod_s2[1]) : prod_s2[1])
				+ (neg_s2[2] ? dword_t'(-prod_s2[2]) : prod_s2[2]);
			ctx_s4 <= ctx4_d;
			ctx_s5 <= ctx5_d;
			pp_s5  <= mul_pp(ctx_s4.c1, ctx_s4.c1);
			ctx_s6 <= ctx_s5;
			rad_s6 <= ONE2 - pp_sum(pp_s5);
		end
	end

	logic                     q1_v;
	word_t                    q1_root;
	logic [$bits(ctx_t)-1:0]  q1_pay;
	ctx_t                     q1_ctx;

	srv_isqrt #(.PW($bits(ctx_t))) u_sine (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s6),
		.in_rad   (rad_s6),
		.in_pay   (ctx_s6),
		.out_v    (q1_v),
		.out_root (q1_root),
		.out_pay  (q1_pay)
	);

	assign q1_ctx = q1_pay;

	// Total-reflection test and the refracted sine, s1*n1/n2.
	logic   v_s7, v_s8;
	ctx_t   ctx_s7, ctx_s8;
	pp_t    pp_s7;
	dword_t sn_s8;

	logic   d1_v   [0:F];
	word_t  d1_rem [0:F];
	word_t  d1_num [0:F];
	word_t  d1_q   [0:F];
	ctx_t   d1_ctx [0:F];
	logic   d1_tir [0:F];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7    <= 1'b0;
			v_s8    <= 1'b0;
			d1_v[0] <= 1'b0;
		end else if (en) begin
			v_s7    <= q1_v;
			v_s8    <= v_s7;
			d1_v[0] <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s7    <= q1_ctx;
			pp_s7     <= mul_pp(q1_root, {1'b0, q1_ctx.n1});
			ctx_s8    <= ctx_s7;
			sn_s8     <= pp_sum(pp_s7);
			d1_ctx[0] <= ctx_s8;
			d1_tir[0] <= sn_s8 >= (dword_t'(ctx_s8.n2) << F);
			d1_rem[0] <= sn_s8[F +: 64];
			d1_num[0] <= word_t'(sn_s8[63:0] << (64 - F));
			d1_q[0]   <= '0;
		end
	end

	for (genvar k = 0; k < F; k++) begin : g_div1
		logic [64:0] r;
		logic        ge;

		assign r  = {d1_rem[k], d1_num[k][63]};
		assign ge = (r >= {2'b00, d1_ctx[k].n2});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d1_v[k+1] <= 1'b0;
			end else if (en) begin
				d1_v[k+1] <= d1_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d1_rem[k+1] <= ge ? 64'(r - {2'b00, d1_ctx[k].n2}) : r[63:0];
				d1_num[k+1] <= {d1_num[k][62:0], 1'b0};
				d1_q[k+1]   <= {d1_q[k][62:0], ge};
				d1_ctx[k+1] <= d1_ctx[k];
				d1_tir[k+1] <= d1_tir[k];
			end
		end
	end

	// Refracted cosine radicand and the n1*c1 term.
	logic   v_s10, v_s11, v_s12;
	ctx_t   ctx_s10, ctx_s11;
	logic   tir_s10, tir_s11;
	pp_t    ppa_s10, ppb_s10;
	dword_t ss_s11, pf_s11;
	dword_t rad_s12;
	pay2_t  pay_s12;
	dword_t pf_sh;

	assign pf_sh = pf_s11 >> F;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s10 <= d1_v[F];
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s10     <= d1_ctx[F];
			tir_s10     <= d1_tir[F];
			ppa_s10     <= mul_pp(d1_q[F], d1_q[F]);
			ppb_s10     <= mul_pp({1'b0, d1_ctx[F].n1}, d1_ctx[F].c1);
			ctx_s11     <= ctx_s10;
			tir_s11     <= tir_s10;
			ss_s11      <= pp_sum(ppa_s10);
			pf_s11      <= pp_sum(ppb_s10);
			rad_s12     <= ONE2 - ss_s11;
			pay_s12.ctx <= ctx_s11;
			pay_s12.tir <= tir_s11;
			pay_s12.p   <= pf_sh[63:0];
		end
	end

	logic                     q2_v;
	word_t                    q2_root;
	logic [$bits(pay2_t)-1:0] q2_pay;
	pay2_t                    q2;

	srv_isqrt #(.PW($bits(pay2_t))) u_cosine (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s12),
		.in_rad   (rad_s12),
		.in_pay   (pay_s12),
		.out_v    (q2_v),
		.out_root (q2_root),
		.out_pay  (q2_pay)
	);

	assign q2 = q2_pay;

	// New direction before normalization.
	logic   v_s13, v_s14, v_s15, v_s16, v_s17, v_s18, v_s19, v_s20, v_s21, v_s22;
	pay2_t  pay_s13, pay_s14;
	pp_t    pp_s13;
	dword_t qf_s14;
	ctx_t   ctx_s15, ctx_s16, ctx_s17, ctx_s18, ctx_s19, ctx_s20, ctx_s21;
	word_t  amul_s15, bmag_s15;
	logic   bneg_s15;
	logic [1:0] code_s15, code_s16, code_s17, code_s18, code_s19, code_s20, code_s21;
	pp_t [2:0]    ppa_s16, ppb_s16;
	logic [2:0]   sa_s16, sb_s16, sa_s17, sb_s17;
	dword_t [2:0] ta_s17, tb_s17, sum_s18;
	logic [2:0]   vn_s19, vn_s20, vn_s21;
	word_t [2:0]  vm_s19, vm_s20, vm_s21;
	pp_t [2:0]    pp_s20;
	dword_t [2:0] sq_s21;
	dword_t       len2_s22;
	pay3_t        pay_s22;

	dword_t       qsh15;
	word_t        qv15;
	dword_t [2:0] abs19;
	dword_t [2:0] sh19;

	always_comb begin
		qsh15 = qf_s14 >> F;
		qv15  = qsh15[63:0];
		for (int j = 0; j < 3; j++) begin
			abs19[j] = sum_s18[j][127] ? dword_t'(-sum_s18[j]) : sum_s18[j];
			sh19[j]  = abs19[j] >> (F + 2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
			v_s17 <= 1'b0;
			v_s18 <= 1'b0;
			v_s19 <= 1'b0;
			v_s20 <= 1'b0;
			v_s21 <= 1'b0;
			v_s22 <= 1'b0;
		end else if (en) begin
			v_s13 <= q2_v;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
			v_s17 <= v_s16;
			v_s18 <= v_s17;
			v_s19 <= v_s18;
			v_s20 <= v_s19;
			v_s21 <= v_s20;
			v_s22 <= v_s21;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s13 <= q2;
			pp_s13  <= mul_pp({1'b0, q2.ctx.n2}, q2_root);
			pay_s14 <= pay_s13;
			qf_s14  <= pp_sum(pp_s13);

			ctx_s15 <= pay_s14.ctx;
			if (pay_s14.tir) begin
				amul_s15 <= ONE;
				bmag_s15 <= pay_s14.ctx.c1 << 1;
				bneg_s15 <= 1'b0;
				code_s15 <= OUT_REFLECT;
			end else begin
				amul_s15 <= {1'b0, pay_s14.ctx.n1};
				bmag_s15 <= (qv15 > pay_s14.p) ? qv15 - pay_s14.p : pay_s14.p - qv15;
				bneg_s15 <= qv15 > pay_s14.p;
				code_s15 <= OUT_REFRACT;
			end

			ctx_s16  <= ctx_s15;
			code_s16 <= code_s15;
			ctx_s17  <= ctx_s16;
			code_s17 <= code_s16;
			sa_s17   <= sa_s16;
			sb_s17   <= sb_s16;
			ctx_s18  <= ctx_s17;
			code_s18 <= code_s17;
			ctx_s19  <= ctx_s18;
			code_s19 <= code_s18;
			ctx_s20  <= ctx_s19;
			code_s20 <= code_s19;
			vm_s20   <= vm_s19;
			vn_s20   <= vn_s19;
			ctx_s21  <= ctx_s20;
			code_s21 <= code_s20;
			vm_s21   <= vm_s20;
			vn_s21   <= vn_s20;
			for (int j = 0; j < 3; j++) begin
				ppa_s16[j] <= mul_pp(amul_s15, sat_mag(ctx_s15.dir[j]));
				ppb_s16[j] <= mul_pp(bmag_s15, sat_mag(ctx_s15.nrm[j]));
				sa_s16[j]  <= ctx_s15.dir[j][63];
				sb_s16[j]  <= ctx_s15.nrm[j][63] ^ ctx_s15.flip ^ bneg_s15;
				ta_s17[j]  <= pp_sum(ppa_s16[j]);
				tb_s17[j]  <= pp_sum(ppb_s16[j]);
				sum_s18[j] <= (sa_s17[j] ? dword_t'(-ta_s17[j]) : ta_s17[j])
					+ (sb_s17[j] ? dword_t'(-tb_s17[j]) : tb_s17[j]);
				vn_s19[j]  <= sum_s18[j][127];
				vm_s19[j]  <= sh19[j][63:0];
				pp_s20[j]  <= mul_pp(vm_s19[j], vm_s19[j]);
				sq_s21[j]  <= pp_sum(pp_s20[j]);
			end
			len2_s22     <= sq_s21[0] + sq_s21[1] + sq_s21[2];
			pay_s22.ctx  <= ctx_s21;
			pay_s22.code <= code_s21;
			pay_s22.vm   <= vm_s21;
			pay_s22.vn   <= vn_s21;
		end
	end

	logic                     q3_v;
	word_t                    q3_root;
	logic [$bits(pay3_t)-1:0] q3_pay;
	pay3_t                    q3;

	srv_isqrt #(.PW($bits(pay3_t))) u_length (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s22),
		.in_rad   (len2_s22),
		.in_pay   (pay_s22),
		.out_v    (q3_v),
		.out_root (q3_root),
		.out_pay  (q3_pay)
	);

	assign q3 = q3_pay;

	// Normalization: three parallel dividers by the length.
	logic            e_v    [0:F+1];
	word_t [2:0]     e_rem  [0:F+1];
	word_t [2:0]     e_num  [0:F+1];
	word_t [2:0]     e_q    [0:F+1];
	word_t           e_len  [0:F+1];
	logic            e_zero [0:F+1];
	pay3_t           e_pay  [0:F+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_v[0] <= 1'b0;
		end else if (en) begin
			e_v[0] <= q3_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_len[0]  <= q3_root;
			e_zero[0] <= (q3_root == '0);
			e_pay[0]  <= q3;
			for (int j = 0; j < 3; j++) begin
				e_rem[0][j] <= {1'b0, q3.vm[j][63:1]};
				e_num[0][j] <= {q3.vm[j][0], 63'd0};
				e_q[0][j]   <= '0;
			end
		end
	end

	for (genvar k = 0; k <= F; k++) begin : g_div2
		logic [2:0][64:0] r;
		logic [2:0]       ge;

		for (genvar j = 0; j < 3; j++) begin : g_lane
			assign r[j]  = {e_rem[k][j], e_num[k][j][63]};
			assign ge[j] = (r[j] >= {1'b0, e_len[k]});

			always_ff @(posedge clk) begin
				if (en) begin
					e_rem[k+1][j] <= ge[j] ? 64'(r[j] - {1'b0, e_len[k]}) : r[j][63:0];
					e_num[k+1][j] <= {e_num[k][j][62:0], 1'b0};
					e_q[k+1][j]   <= {e_q[k][j][62:0], ge[j]};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				e_v[k+1] <= 1'b0;
			end else if (en) begin
				e_v[k+1] <= e_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				e_len[k+1]  <= e_len[k];
				e_zero[k+1] <= e_zero[k];
				e_pay[k+1]  <= e_pay[k];
			end
		end
	end

	// Output register.
	pay3_t       fin;
	logic        fin_keep;
	word_t [2:0] fin_dir;

	always_comb begin
		fin      = e_pay[F+1];
		fin_keep = fin.ctx.keep || e_zero[F+1];
		for (int j = 0; j < 3; j++) begin
			if (fin_keep) begin
				fin_dir[j] = fin.ctx.dir[j];
			end else begin
				fin_dir[j] = fin.vn[j] ? word_t'(-e_q[F+1][j]) : e_q[F+1][j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= e_v[F+1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			new_x   <= fin_dir[0];
			new_y   <= fin_dir[1];
			new_z   <= fin_dir[2];
			outcome <= fin_keep ? OUT_KEEP : fin.code;
		end
	end

	`SRV_ASSERT_NOW(a_unit_bound,
		result_valid && outcome != OUT_KEEP,
		(word_t'(new_x[63] ? -new_x : new_x) <= ONE)
			&& (word_t'(new_y[63] ? -new_y : new_y) <= ONE)
			&& (word_t'(new_z[63] ? -new_z : new_z) <= ONE),
		"redirected component exceeds unit magnitude")

	`SRV_ASSERT_NOW(a_nonzero_dir,
		result_valid && outcome != OUT_KEEP,
		new_x != '0 || new_y != '0 || new_z != '0,
		"redirected direction has zero length")

	`SRV_ASSERT_NEXT(a_freeze_holds,
		v_s1 && !en,
		v_s1,
		"frozen pipeline dropped its first-stage item")

endmodule

FILE: rtl/srv_isqrt.sv
// Pipelined floor square root of a 128-bit value, one root bit per stage.
module srv_isqrt import srv_pkg::*; #(
	parameter int PW = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_v,
	input  dword_t               in_rad,
	input  logic [PW-1:0]        in_pay,
	output logic                 out_v,
	output logic [ROOT_W-1:0]    out_root,
	output logic [PW-1:0]        out_pay
);

	localparam int REM_W = ROOT_W + 2;

	logic                v_s    [1:ROOT_W];
	dword_t              x_s    [1:ROOT_W];
	logic [REM_W-1:0]    rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0]   root_s [1:ROOT_W];
	logic [PW-1:0]       pay_s  [1:ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic              pv;
		dword_t            px;
		logic [REM_W-1:0]  prem;
		logic [ROOT_W-1:0] proot;
		logic [PW-1:0]     ppay;
		logic [REM_W+1:0]  r;
		logic [REM_W+1:0]  t;
		logic              ge;

		if (k == 0) begin : g_head
			assign pv    = in_v;
			assign px    = in_rad;
			assign prem  = '0;
			assign proot = '0;
			assign ppay  = in_pay;
		end else begin : g_body
			assign pv    = v_s[k];
			assign px    = x_s[k];
			assign prem  = rem_s[k];
			assign proot = root_s[k];
			assign ppay  = pay_s[k];
		end

		assign r  = {prem, px[RAD_W-1 -: 2]};
		assign t  = {2'b00, proot, 2'b01};
		assign ge = (r >= t);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]    <= px << 2;
				rem_s[k+1]  <= ge ? REM_W'(r - t) : r[REM_W-1:0];
				root_s[k+1] <= {proot[ROOT_W-2:0], ge};
				pay_s[k+1]  <= ppay;
			end
		end
	end

	assign out_v    = v_s[ROOT_W];
	assign out_root = root_s[ROOT_W];
	assign out_pay  = pay_s[ROOT_W];

endmodule
